/* rtl/dfjg_pkg.sv */
// Package for the delimited field jump gate.
// Holds register map codes, reset values and character constants.
// Has no dependencies.
package dfjg_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int THRESH_W   = 31;
  localparam int FIELD_W    = 32;
  localparam int COORD_W    = 16;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_SEPARATOR = 1'b1
  } cfg_reg_t;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 31'd500;
  localparam logic [7:0]          SEPARATOR_RESET = 8'd44;
  localparam logic [7:0]          ASCII_ZERO      = 8'd48;
  localparam logic [FIELD_W-1:0]  FIELD_SCALE     = 32'd10;
  localparam logic [COORD_W-1:0]  REJECT_COORD    = 16'hFFFF;
  localparam int                  FIRST_COMPARED  = 2;

endpackage

/* rtl/delimited_field_jump_gate.sv */
// Top level of the delimited field jump gate: parses delimited numeric fields
// and accepts or rejects each message by its squared jump from the last one.
// Depends on dfjg_pkg.

// The block takes one message byte per cycle on the in_ stream, with tlast
// marking the final byte of a message, and returns one transaction per message
// on the out_ stream holding fields 0 and 1 (or all ones when rejected) and an
// accepted flag in tuser. The path is a four-stage pipeline: an input register,
// the field update with the per-field differences, the squares, and the sum
// with the threshold compare into the output register. out_tvalid rises once the
// final byte has passed the input, difference and square registers into the output
// register, and a new byte can be taken every cycle; when out_tready is low with
// a result waiting, the whole pipeline holds.
module delimited_field_jump_gate #(
  parameter int MAX_FIELDS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: msg_byte[7:0]; in_tlast: is_final
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  // out_tdata: x_out[15:0], y_out[31:16]; out_tuser: accepted
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dfjg_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [dfjg_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [dfjg_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int IDX_W = $clog2(MAX_FIELDS);
  localparam int SEP_W = $clog2(MAX_FIELDS + 1);
  localparam int SUM_W = dfjg_pkg::FIELD_W + $clog2(MAX_FIELDS);
  localparam int FW    = dfjg_pkg::FIELD_W;
  localparam int CW    = dfjg_pkg::COORD_W;

  logic [dfjg_pkg::THRESH_W-1:0] thresh_r;
  logic [7:0]                    sep_byte_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_final_r;

  logic [FW-1:0]    fields_r [MAX_FIELDS];
  logic [FW-1:0]    fields_nxt [MAX_FIELDS];
  logic [FW-1:0]    prev_r [MAX_FIELDS];
  logic [FW-1:0]    prev_nxt [MAX_FIELDS];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SEP_W-1:0] sep_r, sep_nxt;
  logic             in_msg_r, in_msg_nxt;

  logic          s2_valid_r;
  logic [CW-1:0] s2_x_r, s2_x_nxt;
  logic [CW-1:0] s2_y_r, s2_y_nxt;
  logic [CW-1:0] s2_mag_r [MAX_FIELDS];
  logic [CW-1:0] s2_mag_nxt [MAX_FIELDS];
  logic          s2_big_r, s2_big_nxt;

  logic          s3_valid_r;
  logic [CW-1:0] s3_x_r;
  logic [CW-1:0] s3_y_r;
  logic [FW-1:0] s3_sq_r [MAX_FIELDS];
  logic          s3_big_r;

  logic          out_valid_r;
  logic [CW-1:0] out_x_r;
  logic [CW-1:0] out_y_r;
  logic          out_acc_r, out_acc_nxt;

  logic en;
  logic cfg_write;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= dfjg_pkg::THRESHOLD_RESET;
      sep_byte_r <= dfjg_pkg::SEPARATOR_RESET;
    end else if (cfg_write) begin
      case (dfjg_pkg::cfg_reg_t'(cfg_paddr[2]))
        dfjg_pkg::REG_THRESHOLD: thresh_r   <= cfg_pwdata[dfjg_pkg::THRESH_W-1:0];
        dfjg_pkg::REG_SEPARATOR: sep_byte_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (dfjg_pkg::cfg_reg_t'(cfg_paddr[2]))
      dfjg_pkg::REG_THRESHOLD: cfg_prdata = {1'b0, thresh_r};
      dfjg_pkg::REG_SEPARATOR: cfg_prdata = {24'd0, sep_byte_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  always_comb begin
    logic [FW:0] diff;
    logic [FW:0] mag;
    logic        used;
    idx_nxt    = in_msg_r ? idx_r : '0;
    sep_nxt    = in_msg_r ? sep_r : '0;
    for (int i = 0; i < MAX_FIELDS; i++) begin
      fields_nxt[i] = in_msg_r ? fields_r[i] : '0;
    end
    if (s1_byte_r == sep_byte_r) begin
      if (idx_nxt < IDX_W'(MAX_FIELDS - 1)) begin
        idx_nxt = idx_nxt + 1'b1;
      end
      if (sep_nxt < SEP_W'(MAX_FIELDS)) begin
        sep_nxt = sep_nxt + 1'b1;
      end
    end else begin
      fields_nxt[idx_nxt] = fields_nxt[idx_nxt] * dfjg_pkg::FIELD_SCALE
                            + {24'd0, s1_byte_r} - {24'd0, dfjg_pkg::ASCII_ZERO};
    end
    in_msg_nxt = !s1_final_r;
    s2_x_nxt   = fields_nxt[0][CW-1:0];
    s2_y_nxt   = fields_nxt[1][CW-1:0];
    s2_big_nxt = 1'b0;
    for (int i = 0; i < MAX_FIELDS; i++) begin
      diff = {fields_nxt[i][FW-1], fields_nxt[i]} - {prev_r[i][FW-1], prev_r[i]};
      mag  = diff[FW] ? (~diff + 1'b1) : diff;
      used = (i >= dfjg_pkg::FIRST_COMPARED) && (SEP_W'(i) < sep_nxt);
      s2_mag_nxt[i] = used ? mag[CW-1:0] : '0;
      if (used && (mag[FW:CW] != '0)) begin
        s2_big_nxt = 1'b1;
      end
      prev_nxt[i] = (s1_final_r && (SEP_W'(i) < sep_nxt)) ? fields_nxt[i] : prev_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      in_msg_r   <= 1'b0;
      idx_r      <= '0;
      sep_r      <= '0;
      for (int i = 0; i < MAX_FIELDS; i++) begin
        prev_r[i] <= '0;
      end
    end else if (en) begin
      s1_valid_r <= in_tvalid;
      if (s1_valid_r) begin
        in_msg_r <= in_msg_nxt;
        idx_r    <= idx_nxt;
        sep_r    <= sep_nxt;
        for (int i = 0; i < MAX_FIELDS; i++) begin
          prev_r[i] <= prev_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_byte_r  <= in_tdata;
      s1_final_r <= in_tlast;
      if (s1_valid_r) begin
        for (int i = 0; i < MAX_FIELDS; i++) begin
          fields_r[i] <= fields_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r  <= s1_valid_r && s1_final_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x_r   <= s2_x_nxt;
      s2_y_r   <= s2_y_nxt;
      s2_big_r <= s2_big_nxt;
      for (int i = 0; i < MAX_FIELDS; i++) begin
        s2_mag_r[i] <= s2_mag_nxt[i];
        s3_sq_r[i]  <= s2_mag_r[i] * s2_mag_r[i];
      end
      s3_x_r    <= s2_x_r;
      s3_y_r    <= s2_y_r;
      s3_big_r  <= s2_big_r;
      out_acc_r <= out_acc_nxt;
      out_x_r   <= out_acc_nxt ? s3_x_r : dfjg_pkg::REJECT_COORD;
      out_y_r   <= out_acc_nxt ? s3_y_r : dfjg_pkg::REJECT_COORD;
    end
  end

  always_comb begin
    logic [SUM_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < MAX_FIELDS; i++) begin
      sum = sum + SUM_W'(s3_sq_r[i]);
    end
    out_acc_nxt = !s3_big_r && (sum < SUM_W'(thresh_r));
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_acc_r;

endmodule

/* tb/sv/delimited_field_jump_gate_test.sv */
// Self-checking testbench for delimited_field_jump_gate: streams message bytes with
// random idling on both sides, predicts every gate decision and checks each result.
// Depends on dfjg_pkg and the delimited_field_jump_gate RTL.
module delimited_field_jump_gate_test;

  localparam int FIELD_COUNT    = 5;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BYTES    = 230;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        accepted;
  } gate_verdict_t;

  class jump_gate_scoreboard;
    logic [31:0]   cur_f[FIELD_COUNT];
    logic [31:0]   prev_f[FIELD_COUNT];
    int unsigned   field_idx;
    int unsigned   sep_seen;
    bit            in_msg;
    logic [30:0]   threshold;
    logic [7:0]    separator;
    gate_verdict_t pending[$];
    int            errors;

    function new();
      threshold = 31'd500;
      separator = 8'd44;
      in_msg = 0;
      field_idx = 0;
      sep_seen = 0;
      errors = 0;
      foreach (cur_f[i]) begin
        cur_f[i] = '0;
        prev_f[i] = '0;
      end
    endfunction

    function void fail(string what);
      errors++;
      if (errors <= 10) $display("[%0t] %s", $realtime, what);
    endfunction

    function void set_reg(dfjg_pkg::cfg_reg_t reg_id, logic [31:0] value);
      if (reg_id == dfjg_pkg::REG_THRESHOLD) threshold = value[30:0];
      else separator = value[7:0];
    endfunction

    function logic [31:0] reg_value(dfjg_pkg::cfg_reg_t reg_id);
      if (reg_id == dfjg_pkg::REG_THRESHOLD) return {1'b0, threshold};
      return {24'd0, separator};
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      logic signed [32:0] diff;
      logic        [32:0] mag;
      longint unsigned    sq_sum;
      bit                 too_far;
      gate_verdict_t      v;
      if (!in_msg) begin
        foreach (cur_f[i]) cur_f[i] = '0;
        field_idx = 0;
        sep_seen = 0;
        in_msg = 1;
      end
      if (b == separator) begin
        if (field_idx < FIELD_COUNT - 1) field_idx++;
        if (sep_seen < FIELD_COUNT) sep_seen++;
      end else begin
        cur_f[field_idx] = cur_f[field_idx] * 32'd10 + {24'd0, b} - 32'd48;
      end
      if (!fin) return;
      sq_sum = 0;
      too_far = 0;
      for (int i = 2; i < sep_seen; i++) begin
        diff = $signed({cur_f[i][31], cur_f[i]}) - $signed({prev_f[i][31], prev_f[i]});
        mag = diff < 0 ? -diff : diff;
        if (mag >= 33'd65536) too_far = 1;
        else sq_sum += longint'(mag) * longint'(mag);
      end
      if (!too_far && sq_sum < longint'(threshold)) begin
        v.x = cur_f[0][15:0];
        v.y = cur_f[1][15:0];
        v.accepted = 1'b1;
      end else begin
        v.x = 16'hFFFF;
        v.y = 16'hFFFF;
        v.accepted = 1'b0;
      end
      pending.push_back(v);
      for (int i = 0; i < sep_seen; i++) prev_f[i] = cur_f[i];
      in_msg = 0;
    endfunction

    function void check_result(logic [31:0] data, logic accepted);
      gate_verdict_t v;
      if (pending.size() == 0) begin
        fail($sformatf("unexpected result x=%h y=%h accepted=%b",
                       data[15:0], data[31:16], accepted));
        return;
      end
      v = pending.pop_front();
      if (data[15:0] !== v.x || data[31:16] !== v.y || accepted !== v.accepted)
        fail($sformatf("result expected x=%h y=%h accepted=%b, got x=%h y=%h accepted=%b",
                       v.x, v.y, v.accepted, data[15:0], data[31:16], accepted));
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [31:0]                     out_tdata;
  logic                            out_tuser;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [dfjg_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [dfjg_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [dfjg_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  jump_gate_scoreboard sb = new();
  logic [7:0]          msg_text[$];
  bit                  steady;
  int                  bytes_sent;
  int                  idle_cycles;

  delimited_field_jump_gate #(.MAX_FIELDS(FIELD_COUNT)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("delimited_field_jump_gate: mismatch");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!steady && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input dfjg_pkg::cfg_reg_t reg_id, input bit wr,
                            input logic [31:0] value);
    logic [31:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= dfjg_pkg::CFG_ADDR_W'(4 * int'(reg_id));
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (wr) begin
      sb.set_reg(reg_id, value);
    end else if (got !== sb.reg_value(reg_id)) begin
      sb.fail($sformatf("register %s read expected %h got %h",
                        reg_id.name(), sb.reg_value(reg_id), got));
    end
  endtask

  task automatic program_gate(input logic [31:0] threshold, input logic [31:0] separator);
    cfg_access(dfjg_pkg::REG_THRESHOLD, 1'b1, threshold);
    cfg_access(dfjg_pkg::REG_SEPARATOR, 1'b1, separator);
    cfg_access(dfjg_pkg::REG_THRESHOLD, 1'b0, '0);
    cfg_access(dfjg_pkg::REG_SEPARATOR, 1'b0, '0);
  endtask

  function automatic void push_decimal(logic [31:0] value);
    logic [7:0] digits[$];
    do begin
      digits.push_front(8'd48 + 8'(value % 10));
      value = value / 10;
    end while (value != 0);
    foreach (digits[i]) msg_text.push_back(digits[i]);
  endfunction

  function automatic logic [31:0] field_step(int jump);
    if (jump < 60) return 32'($urandom_range(24)) - 32'd12;
    if (jump < 85) return 32'($urandom_range(120)) - 32'd60;
    return $urandom;
  endfunction

  task automatic build_message(input bit tidy);
    int          nsep;
    int          r;
    int          jump;
    int          pos;
    logic [31:0] value;
    msg_text.delete();
    r = $urandom_range(99);
    nsep = r < 55 ? 4 : r < 70 ? 3 : r < 82 ? $urandom_range(7, 5) : $urandom_range(2);
    jump = $urandom_range(99);
    for (int k = 0; k <= nsep; k++) begin
      if (k > 0) msg_text.push_back(sb.separator);
      if (k < 2) value = $urandom_range(3) == 0 ? $urandom : $urandom_range(70000);
      else if (k < FIELD_COUNT) value = sb.prev_f[k] + field_step(jump);
      else value = $urandom_range(9);
      if (value != 0 || $urandom_range(3) != 0) push_decimal(value);
    end
    if ($urandom_range(9) == 0) msg_text.push_back(sb.separator);
    if (!tidy && msg_text.size() != 0) begin
      pos = $urandom_range(msg_text.size() - 1);
      r = $urandom_range(2);
      if (r == 0) msg_text.insert(pos, 8'($urandom_range(255)));
      else if (r == 1) msg_text.delete(pos);
      else msg_text[pos] = 8'($urandom_range(255));
    end
    if (msg_text.size() == 0) msg_text.push_back(8'd48);
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    int kind;
    int n;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 85) begin
        build_message(kind < 70);
        foreach (msg_text[i]) send_byte(msg_text[i], i == msg_text.size() - 1);
      end else begin
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(255)), i == n - 1 || $urandom_range(9) == 0);
      end
    end
    settle();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    steady      = 0;
    bytes_sent  = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text(",");
    send_text(",,99,");
    send_text(",,,,,,7");
    send_text(",,~~~~,");
    send_text("12,34");
    settle();

    run_phase(PHASE_BYTES);
    program_gate(32'd0, 32'd44);
    run_phase(PHASE_BYTES);
    program_gate(32'hFFFF_FFFF, 32'hABCD_00FF);
    run_phase(PHASE_BYTES);
    program_gate(32'($urandom_range(2000, 1)), 32'd0);
    run_phase(PHASE_BYTES);
    program_gate(32'd1, 32'd59);
    steady = 1;
    run_phase(PHASE_BYTES);
    steady = 0;
    program_gate($urandom, $urandom);
    run_phase(PHASE_BYTES);
    program_gate(32'd500, 32'd44);
    run_phase(PHASE_BYTES);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("delimited_field_jump_gate: match");
    end else begin
      $display("delimited_field_jump_gate: mismatch");
    end
    $finish;
  end
endmodule
